/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the transfer splitter modules.
// Defining NO_ASSERTIONS leaves every macro empty.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ETS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define ETS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ETS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ETS_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ETS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ETS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/ets_pkg.sv */
// Types and constants of the EEPROM transfer splitter.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package ets_pkg;

    localparam int unsigned MAX_PAGE = 256;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned LEN_W   = 32;
    localparam int unsigned SIZE_W  = 33;
    localparam int unsigned PAGE_W  = 16;
    localparam int unsigned CHUNK_W = 16;
    localparam int unsigned CFG_W   = 33;
    localparam int unsigned DIV_BITS_PER_STEP = 2;
    localparam int unsigned DIV_STEPS = ADDR_W / DIV_BITS_PER_STEP;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;

    localparam logic [1:0] CFG_ENABLED    = 2'd0;
    localparam logic [1:0] CFG_MEM_BYTES  = 2'd1;
    localparam logic [1:0] CFG_PAGE_BYTES = 2'd2;
    localparam logic [1:0] CFG_ADDR_MODE  = 2'd3;

    localparam logic [1:0] MODE_8  = 2'd0;
    localparam logic [1:0] MODE_16 = 2'd1;
    localparam logic [1:0] MODE_24 = 2'd2;

    typedef enum logic [2:0] {
        ST_ACCEPTED  = 3'd0,
        ST_CHUNK     = 3'd1,
        ST_IDLE_CODE = 3'd2,
        ST_NOT_INIT  = 3'd3,
        ST_ZERO_LEN  = 3'd4,
        ST_OUT_RANGE = 3'd5,
        ST_CFG_ERR   = 3'd6,
        ST_BUSY      = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_DIV,
        FSM_EMIT
    } fsm_state_t;

    typedef struct packed {
        logic    start_xfer;
        logic    start_write;
        logic    put_status;
        status_t code;
        logic    div_init;
        logic    div_step;
        logic    put_chunk;
    } ctl_cmd_t;

    typedef struct packed {
        logic enabled;
        logic cfg_ok;
        logic active;
        logic writing;
        logic len_zero;
        logic out_of_range;
        logic div_last;
    } dp_stat_t;

endpackage

/* hw/rtl/ets_ctrl.sv */
// Controller state machine of the EEPROM transfer splitter.
// Decides the status of each request and sequences the page remainder unit.
// Depends on ets_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ets_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       cmd,
    input  ets_pkg::dp_stat_t stat,
    output ets_pkg::ctl_cmd_t ctl,
    output logic             busy
);
    import ets_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;
    logic       is_start;

    assign is_start = (cmd == CMD_READ) || (cmd == CMD_WRITE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        ctl             = '0;
        ctl.code        = ST_ACCEPTED;
        ctl.start_write = (cmd == CMD_WRITE);
        busy            = 1'b1;
        case (state_reg)
            FSM_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (is_start)
                    begin
                        ctl.put_status = 1'b1;
                        if (!stat.enabled)
                        begin
                            ctl.code = ST_NOT_INIT;
                        end
                        else if (!stat.cfg_ok)
                        begin
                            ctl.code = ST_CFG_ERR;
                        end
                        else if (stat.active)
                        begin
                            ctl.code = ST_BUSY;
                        end
                        else if (stat.len_zero)
                        begin
                            ctl.code = ST_ZERO_LEN;
                        end
                        else if (stat.out_of_range)
                        begin
                            ctl.code = ST_OUT_RANGE;
                        end
                        else
                        begin
                            ctl.code       = ST_ACCEPTED;
                            ctl.start_xfer = 1'b1;
                        end
                    end
                    else if (!stat.active)
                    begin
                        ctl.put_status = 1'b1;
                        ctl.code       = ST_IDLE_CODE;
                    end
                    else if (!stat.enabled)
                    begin
                        ctl.put_status = 1'b1;
                        ctl.code       = ST_NOT_INIT;
                    end
                    else if (!stat.cfg_ok)
                    begin
                        ctl.put_status = 1'b1;
                        ctl.code       = ST_CFG_ERR;
                    end
                    else if (stat.writing)
                    begin
                        ctl.div_init = 1'b1;
                        state_next   = FSM_DIV;
                    end
                    else
                    begin
                        ctl.put_chunk = 1'b1;
                    end
                end
            end
            FSM_DIV:
            begin
                ctl.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = FSM_EMIT;
                end
            end
            FSM_EMIT:
            begin
                ctl.put_chunk = 1'b1;
                state_next    = FSM_IDLE;
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    `ETS_ASSERT_ALWAYS(a_one_result, clk, rst_n, !(ctl.put_chunk && ctl.put_status))
    `ETS_ASSERT_IMPLIES(a_div_from_idle, clk, rst_n, ctl.div_init,
        (state_reg == FSM_IDLE) && start && stat.writing)
    `ETS_ASSERT_IMPLIES(a_emit_after_div, clk, rst_n, state_reg == FSM_EMIT,
        $past(state_reg) == FSM_DIV)

endmodule

/* hw/rtl/ets_datapath.sv */
// Datapath of the EEPROM transfer splitter: configuration, transfer state,
// the two-bit-a-cycle page remainder unit and the result register.
// Depends on ets_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ets_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [1:0]                  cfg_index,
    input  logic [ets_pkg::CFG_W-1:0]   cfg_data,
    input  logic [ets_pkg::ADDR_W-1:0]  address,
    input  logic [ets_pkg::LEN_W-1:0]   length,
    input  ets_pkg::ctl_cmd_t           ctl,
    output ets_pkg::dp_stat_t           stat,
    output logic                        result_valid,
    output logic [2:0]                  status,
    output logic [ets_pkg::ADDR_W-1:0]  chunk_addr,
    output logic [ets_pkg::CHUNK_W-1:0] chunk_len,
    output logic [2:0]                  addr_count,
    output logic                        is_write,
    output logic                        wait_after,
    output logic                        last
);
    import ets_pkg::*;

    logic               enabled_reg;
    logic [SIZE_W-1:0]  mem_bytes_reg;
    logic [PAGE_W-1:0]  page_bytes_reg;
    logic [1:0]         addr_mode_reg;

    logic [ADDR_W-1:0]  cur_addr_reg,  cur_addr_next;
    logic [LEN_W-1:0]   remaining_reg, remaining_next;
    logic               active_reg,    active_next;
    logic               writing_reg,   writing_next;

    logic [ADDR_W-1:0]    shift_reg, shift_next;
    logic [PAGE_W-1:0]    rem_reg,   rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg,   cnt_next;

    logic               valid_reg;
    status_t            status_reg;
    logic [ADDR_W-1:0]  chunk_addr_reg;
    logic [CHUNK_W-1:0] chunk_len_reg;
    logic [2:0]         addr_count_reg;
    logic               is_write_reg;
    logic               last_reg;

    logic [SIZE_W-1:0]  size_limit;
    logic [SIZE_W-1:0]  end_addr;
    logic [PAGE_W:0]    try1, try2;
    logic [PAGE_W-1:0]  rem1;
    logic [PAGE_W-1:0]  page_room;
    logic [CHUNK_W-1:0] chunk_max;
    logic [CHUNK_W-1:0] chunk;
    logic [LEN_W-1:0]   remaining_after;

    always_comb
    begin
        case (addr_mode_reg)
            MODE_8:  size_limit = SIZE_W'(64'd256);
            MODE_16: size_limit = SIZE_W'(64'd65536);
            MODE_24: size_limit = SIZE_W'(64'd16777216);
            default: size_limit = SIZE_W'(64'd4294967296);
        endcase
    end

    assign end_addr = {1'b0, address} + {1'b0, length};

    assign stat.enabled      = enabled_reg;
    assign stat.cfg_ok       = (page_bytes_reg != '0)
                               && ({16'd0, page_bytes_reg} <= 32'(MAX_PAGE))
                               && (mem_bytes_reg <= size_limit);
    assign stat.active       = active_reg;
    assign stat.writing      = writing_reg;
    assign stat.len_zero     = (length == '0);
    assign stat.out_of_range = ({1'b0, address} >= mem_bytes_reg)
                               || (end_addr > mem_bytes_reg);
    assign stat.div_last     = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    always_comb
    begin
        try1 = {rem_reg, shift_reg[ADDR_W-1]};
        if (try1 >= {1'b0, page_bytes_reg})
        begin
            try1 = try1 - {1'b0, page_bytes_reg};
        end
        rem1 = try1[PAGE_W-1:0];
        try2 = {rem1, shift_reg[ADDR_W-2]};
        if (try2 >= {1'b0, page_bytes_reg})
        begin
            try2 = try2 - {1'b0, page_bytes_reg};
        end
    end

    assign page_room       = page_bytes_reg - rem_reg;
    assign chunk_max       = writing_reg ? page_room : {CHUNK_W{1'b1}};
    assign chunk           = ({16'd0, chunk_max} > remaining_reg)
                             ? remaining_reg[CHUNK_W-1:0] : chunk_max;
    assign remaining_after = remaining_reg - {16'd0, chunk};

    always_comb
    begin
        cur_addr_next  = cur_addr_reg;
        remaining_next = remaining_reg;
        active_next    = active_reg;
        writing_next   = writing_reg;
        shift_next     = shift_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        if (ctl.start_xfer)
        begin
            cur_addr_next  = address;
            remaining_next = length;
            active_next    = 1'b1;
            writing_next   = ctl.start_write;
        end
        if (ctl.div_init)
        begin
            shift_next = cur_addr_reg;
            rem_next   = '0;
            cnt_next   = '0;
        end
        if (ctl.div_step)
        begin
            shift_next = {shift_reg[ADDR_W-3:0], 2'b00};
            rem_next   = try2[PAGE_W-1:0];
            cnt_next   = cnt_reg + 1'b1;
        end
        if (ctl.put_chunk)
        begin
            cur_addr_next  = cur_addr_reg + {16'd0, chunk};
            remaining_next = remaining_after;
            if (remaining_after == '0)
            begin
                active_next  = 1'b0;
                writing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg    <= 1'b0;
            mem_bytes_reg  <= SIZE_W'(256);
            page_bytes_reg <= PAGE_W'(64);
            addr_mode_reg  <= MODE_8;
            cur_addr_reg   <= '0;
            remaining_reg  <= '0;
            active_reg     <= 1'b0;
            writing_reg    <= 1'b0;
            cnt_reg        <= '0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_ENABLED:    enabled_reg    <= cfg_data[0];
                    CFG_MEM_BYTES:  mem_bytes_reg  <= cfg_data[SIZE_W-1:0];
                    CFG_PAGE_BYTES: page_bytes_reg <= cfg_data[PAGE_W-1:0];
                    CFG_ADDR_MODE:  addr_mode_reg  <= cfg_data[1:0];
                    default:        enabled_reg    <= enabled_reg;
                endcase
            end
            cur_addr_reg  <= cur_addr_next;
            remaining_reg <= remaining_next;
            active_reg    <= active_next;
            writing_reg   <= writing_next;
            cnt_reg       <= cnt_next;
            valid_reg     <= ctl.put_status || ctl.put_chunk;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        if (ctl.put_chunk)
        begin
            status_reg     <= ST_CHUNK;
            chunk_addr_reg <= cur_addr_reg;
            chunk_len_reg  <= chunk;
            addr_count_reg <= {1'b0, addr_mode_reg} + 3'd1;
            is_write_reg   <= writing_reg;
            last_reg       <= (remaining_after == '0);
        end
        else if (ctl.put_status)
        begin
            status_reg     <= ctl.code;
            chunk_addr_reg <= '0;
            chunk_len_reg  <= '0;
            addr_count_reg <= '0;
            is_write_reg   <= 1'b0;
            last_reg       <= 1'b0;
        end
    end

    assign result_valid = valid_reg;
    assign status       = status_reg;
    assign chunk_addr   = chunk_addr_reg;
    assign chunk_len    = chunk_len_reg;
    assign addr_count   = addr_count_reg;
    assign is_write     = is_write_reg;
    assign wait_after   = is_write_reg;
    assign last         = last_reg;

    `ETS_ASSERT_NEXT(a_result_strobe, clk, rst_n, ctl.put_status || ctl.put_chunk,
        valid_reg)
    `ETS_ASSERT_IMPLIES(a_rem_bound, clk, rst_n, ctl.div_step, rem_reg < page_bytes_reg)
    `ETS_ASSERT_IMPLIES(a_chunk_active, clk, rst_n, ctl.put_chunk,
        active_reg && (chunk != '0))

endmodule

/* hw/rtl/eeprom_transfer_splitter.sv */
// Top level of the EEPROM transfer splitter.
// Joins ets_ctrl and ets_datapath; depends on ets_pkg.
//
// A request (cmd, address, length) is taken at a rising edge with start high
// and busy low. Every request gives exactly one result, shown for one cycle
// with result_valid high; the receiver cannot hold it off.
// Start read, start write, and any request that is rejected or finds no
// transfer give their result in the cycle after the request. So does a next
// request during a read. During a write the page offset of the current
// address is found by a remainder unit that takes two address bits a cycle;
// busy stays high through the divide and emit states, and the emit state
// registers the result. A new request may be given in the cycle in which a
// result is shown. The configuration port writes one register per cycle with
// cfg_write high: index 0 enable, 1 total size, 2 page size, 3 address mode.
// It must be written by the user only while busy is low; the block does not
// enforce this. Reset clears the transfer and restores the default
// configuration: disabled, 256 bytes, 64-byte pages, one address byte.
`timescale 1ns / 1ps

module eeprom_transfer_splitter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  cmd,
    input  logic [ets_pkg::ADDR_W-1:0]  address,
    input  logic [ets_pkg::LEN_W-1:0]   length,
    input  logic                        cfg_write,
    input  logic [1:0]                  cfg_index,
    input  logic [ets_pkg::CFG_W-1:0]   cfg_data,
    output logic                        result_valid,
    output logic [2:0]                  status,
    output logic [ets_pkg::ADDR_W-1:0]  chunk_addr,
    output logic [ets_pkg::CHUNK_W-1:0] chunk_len,
    output logic [2:0]                  addr_count,
    output logic                        is_write,
    output logic                        wait_after,
    output logic                        last
);
    import ets_pkg::*;

    ctl_cmd_t ctl;
    dp_stat_t stat;

    ets_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    ets_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .address      (address),
        .length       (length),
        .ctl          (ctl),
        .stat         (stat),
        .result_valid (result_valid),
        .status       (status),
        .chunk_addr   (chunk_addr),
        .chunk_len    (chunk_len),
        .addr_count   (addr_count),
        .is_write     (is_write),
        .wait_after   (wait_after),
        .last         (last)
    );

endmodule

/* verif/testbench.sv */
// Self-checking testbench for eeprom_transfer_splitter.
// A scoreboard class predicts every result from the requests and register writes.
// Depends on ets_pkg and the eeprom_transfer_splitter RTL.
`timescale 1ns / 1ps

module testbench;
    import ets_pkg::*;

    localparam logic [1:0]  CMD_NEXT       = 2'd2;
    localparam logic [1:0]  CMD_SPARE      = 2'd3;
    localparam logic [1:0]  MODE_32        = 2'd3;
    localparam logic [31:0] READ_CHUNK_MAX = 32'd65535;

    typedef struct packed {
        status_t     status;
        logic [31:0] chunk_addr;
        logic [15:0] chunk_len;
        logic [2:0]  addr_count;
        logic        is_write;
        logic        wait_after;
        logic        last;
    } chunk_desc_t;

    class splitter_scoreboard;
        logic        enabled;
        logic [32:0] mem_bytes;
        logic [15:0] page_bytes;
        logic [1:0]  addr_mode;
        logic [31:0] cur_addr;
        logic [31:0] remaining;
        logic        active;
        logic        writing;
        chunk_desc_t pending_descs[$];
        int unsigned errors;

        function new();
            enabled    = 1'b0;
            mem_bytes  = 33'd256;
            page_bytes = 16'd64;
            addr_mode  = MODE_8;
            cur_addr   = '0;
            remaining  = '0;
            active     = 1'b0;
            writing    = 1'b0;
            errors     = 0;
        endfunction

        function void set_register(logic [1:0] index, logic [32:0] value);
            case (index)
                CFG_ENABLED:    enabled    = value[0];
                CFG_MEM_BYTES:  mem_bytes  = value;
                CFG_PAGE_BYTES: page_bytes = value[15:0];
                default:        addr_mode  = value[1:0];
            endcase
        endfunction

        function bit config_ok();
            logic [32:0] ceiling;
            if (page_bytes == 0 || page_bytes > MAX_PAGE)
                return 1'b0;
            case (addr_mode)
                MODE_8:  ceiling = 33'd256;
                MODE_16: ceiling = 33'd65536;
                MODE_24: ceiling = 33'd16777216;
                default: ceiling = 33'h1_0000_0000;
            endcase
            return mem_bytes <= ceiling;
        endfunction

        function bit fits(logic [31:0] a, logic [31:0] l);
            return ({32'd0, a} < {31'd0, mem_bytes}) &&
                   ({32'd0, a} + {32'd0, l} <= {31'd0, mem_bytes});
        endfunction

        function bit would_start(logic [31:0] a, logic [31:0] l);
            return enabled && config_ok() && !active && l != 0 && fits(a, l);
        endfunction

        function void note_request(logic [1:0] c, logic [31:0] a, logic [31:0] l);
            chunk_desc_t r;
            logic [31:0] span;
            r = '0;
            if (c == CMD_READ || c == CMD_WRITE) begin
                if (!enabled)
                    r.status = ST_NOT_INIT;
                else if (!config_ok())
                    r.status = ST_CFG_ERR;
                else if (active)
                    r.status = ST_BUSY;
                else if (l == 0)
                    r.status = ST_ZERO_LEN;
                else if (!fits(a, l))
                    r.status = ST_OUT_RANGE;
                else
                begin
                    cur_addr  = a;
                    remaining = l;
                    active    = 1'b1;
                    writing   = (c == CMD_WRITE);
                    r.status  = ST_ACCEPTED;
                end
            end
            else if (!active)
                r.status = ST_IDLE_CODE;
            else if (!enabled)
                r.status = ST_NOT_INIT;
            else if (!config_ok())
                r.status = ST_CFG_ERR;
            else
            begin
                if (writing)
                    span = {16'd0, page_bytes} - cur_addr % {16'd0, page_bytes};
                else
                    span = READ_CHUNK_MAX;
                if (span > remaining)
                    span = remaining;
                r.status     = ST_CHUNK;
                r.chunk_addr = cur_addr;
                r.chunk_len  = span[15:0];
                r.addr_count = {1'b0, addr_mode} + 3'd1;
                r.is_write   = writing;
                r.wait_after = writing;
                cur_addr     = cur_addr + span;
                remaining    = remaining - span;
                r.last       = (remaining == 0);
                if (remaining == 0)
                begin
                    active  = 1'b0;
                    writing = 1'b0;
                end
            end
            pending_descs.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task check_result(chunk_desc_t got);
            chunk_desc_t want;
            if (pending_descs.size() == 0)
                report($sformatf("result with status %0d and no request outstanding",
                                 got.status));
            else
            begin
                want = pending_descs.pop_front();
                if (got !== want)
                    report($sformatf({"got/expected status %0d/%0d addr %h/%h len %0d/%0d ",
                                      "bytes %0d/%0d wr %b/%b wait %b/%b last %b/%b"},
                                     got.status, want.status, got.chunk_addr, want.chunk_addr,
                                     got.chunk_len, want.chunk_len, got.addr_count,
                                     want.addr_count, got.is_write, want.is_write,
                                     got.wait_after, want.wait_after, got.last, want.last));
            end
        endtask

        task flush_outstanding();
            chunk_desc_t want;
            while (pending_descs.size() != 0)
            begin
                want = pending_descs.pop_front();
                report($sformatf("expected result with status %0d never arrived",
                                 want.status));
            end
        endtask
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          cmd;
    logic [ADDR_W-1:0]   address;
    logic [LEN_W-1:0]    length;
    logic                cfg_write;
    logic [1:0]          cfg_index;
    logic [CFG_W-1:0]    cfg_data;
    logic                result_valid;
    logic [2:0]          status;
    logic [ADDR_W-1:0]   chunk_addr;
    logic [CHUNK_W-1:0]  chunk_len;
    logic [2:0]          addr_count;
    logic                is_write;
    logic                wait_after;
    logic                last;

    splitter_scoreboard sb = new();
    chunk_desc_t        seen;
    int unsigned        idle_pct = 0;
    int unsigned        requests_sent = 0;

    eeprom_transfer_splitter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .address      (address),
        .length       (length),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .status       (status),
        .chunk_addr   (chunk_addr),
        .chunk_len    (chunk_len),
        .addr_count   (addr_count),
        .is_write     (is_write),
        .wait_after   (wait_after),
        .last         (last)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            seen.status     = status_t'(status);
            seen.chunk_addr = chunk_addr;
            seen.chunk_len  = chunk_len;
            seen.addr_count = addr_count;
            seen.is_write   = is_write;
            seen.wait_after = wait_after;
            seen.last       = last;
            sb.check_result(seen);
        end
    end

    task automatic issue(input logic [1:0] c, input logic [31:0] a, input logic [31:0] l);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
        end
        start   <= 1'b1;
        cmd     <= c;
        address <= a;
        length  <= l;
        do @(posedge clk); while (busy);
        sb.note_request(c, a, l);
        requests_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending_descs.size() != 0 || busy)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [32:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        sb.set_register(index, value);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic en, input logic [32:0] total,
                                input logic [15:0] page, input logic [1:0] mode);
        write_reg(CFG_ENABLED, {32'd0, en});
        write_reg(CFG_MEM_BYTES, total);
        write_reg(CFG_PAGE_BYTES, {17'd0, page});
        write_reg(CFG_ADDR_MODE, {31'd0, mode});
    endtask

    initial
    begin
        logic [1:0]      op;
        logic [1:0]      mode;
        logic [31:0]     a;
        logic [31:0]     l;
        logic [32:0]     ceiling;
        logic [32:0]     total;
        logic [15:0]     page;
        logic            en;
        longint unsigned span_cap;
        longint unsigned len;
        longint unsigned size;
        int unsigned     target;

        start     = 1'b0;
        cmd       = CMD_READ;
        address   = '0;
        length    = '0;
        cfg_write = 1'b0;
        cfg_index = CFG_ENABLED;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Straight after reset the device is disabled and holds no transfer.
        issue(CMD_READ, 32'd0, 32'd1);
        issue(CMD_NEXT, 32'd0, 32'd0);
        drain();
        program_regs(1'b1, 33'd256, 16'd64, MODE_8);
        issue(CMD_WRITE, 32'd0, 32'd0);
        issue(CMD_READ, 32'd256, 32'd1);
        issue(CMD_READ, 32'd0, 32'd257);
        issue(CMD_READ, '1, '1);
        issue(CMD_WRITE, 32'd60, 32'd10);
        issue(CMD_NEXT, 32'd0, 32'd0);
        issue(CMD_READ, 32'd0, 32'd1);
        issue(CMD_SPARE, '1, '1);
        issue(CMD_NEXT, 32'd0, 32'd0);

        // A pending transfer must survive a disabled device and a bad page size.
        issue(CMD_WRITE, 32'd0, 32'd100);
        drain();
        write_reg(CFG_ENABLED, 33'd0);
        issue(CMD_NEXT, 32'd0, 32'd0);
        drain();
        write_reg(CFG_ENABLED, 33'd1);
        write_reg(CFG_PAGE_BYTES, 33'd0);
        issue(CMD_NEXT, 32'd0, 32'd0);
        drain();
        write_reg(CFG_PAGE_BYTES, 33'd65535);
        issue(CMD_READ, 32'd0, 32'd1);
        drain();
        write_reg(CFG_PAGE_BYTES, 33'd256);
        issue(CMD_NEXT, 32'd0, 32'd0);
        drain();

        program_regs(1'b1, 33'h1_0000_0000, 16'd1, MODE_32);
        issue(CMD_READ, 32'd0, 32'h0002_0000);
        repeat (3) issue(CMD_NEXT, 32'd0, 32'd0);
        issue(CMD_WRITE, '1, 32'd1);
        issue(CMD_NEXT, 32'd0, 32'd0);
        drain();
        write_reg(CFG_MEM_BYTES, 33'h1_FFFF_FFFF);
        issue(CMD_WRITE, 32'd0, 32'd1);
        drain();
        program_regs(1'b1, 33'd0, 16'd256, MODE_16);
        issue(CMD_READ, 32'd0, 32'd1);
        drain();
        program_regs(1'b1, 33'd257, 16'd64, MODE_8);
        issue(CMD_READ, 32'd0, 32'd1);

        for (int phase = 0; phase < 12; phase++)
        begin
            drain();
            case (phase % 4)
                1:       idle_pct = 62;
                3:       idle_pct = 22;
                default: idle_pct = 0;
            endcase

            mode    = 2'($urandom_range(0, 3));
            ceiling = 33'd1 << (8 * (mode + 1));
            case ($urandom_range(0, 3))
                0:       total = ceiling;
                1:       total = 33'($urandom_range(1, 300));
                default: total = 33'($urandom_range(1, ceiling - 1));
            endcase
            if (total > ceiling)
                total = ceiling;
            case ($urandom_range(0, 3))
                0:       page = 16'd1;
                1:       page = 16'(MAX_PAGE);
                default: page = 16'($urandom_range(2, MAX_PAGE - 1));
            endcase
            en = 1'b1;
            if (phase % 6 == 5)
            begin
                case ($urandom_range(0, 3))
                    0:       en = 1'b0;
                    1:       page = 16'd0;
                    2:       page = 16'($urandom_range(MAX_PAGE + 1, 65535));
                    default: total = (mode == MODE_32) ? 33'h1_FFFF_FFFF : ceiling + 1;
                endcase
            end
            program_regs(en, total, page, mode);

            target = requests_sent + 85;
            while (requests_sent < target)
            begin
                if ($urandom_range(0, 99) < 70)
                begin
                    // Well-formed transfer: a start that mostly fits, then next requests to the end.
                    op   = ($urandom_range(0, 1) == 1) ? CMD_WRITE : CMD_READ;
                    size = 64'(sb.mem_bytes);
                    if (op == CMD_WRITE)
                        span_cap = 64'(sb.page_bytes) * 64'($urandom_range(1, 4)) + 64'd1;
                    else if ($urandom_range(0, 11) == 0)
                        span_cap = 64'd200000;
                    else
                        span_cap = 64'd1024;
                    len = 64'($urandom_range(1, span_cap));
                    if (size != 0 && len > size)
                        len = size;
                    if (size == 0)
                        a = $urandom;
                    else if ($urandom_range(0, 3) == 0)
                        a = 32'(size - len);
                    else
                        a = $urandom_range(0, size - len);
                    if ($urandom_range(0, 9) == 0)
                        len = len + 64'd1;
                    issue(op, a, len[31:0]);
                    while (sb.active)
                    begin
                        if ($urandom_range(0, 11) == 0)
                            issue(($urandom_range(0, 1) == 1) ? CMD_WRITE : CMD_READ,
                                  $urandom, $urandom);
                        else
                            issue(($urandom_range(0, 9) == 0) ? CMD_SPARE : CMD_NEXT,
                                  $urandom, $urandom);
                    end
                    if ($urandom_range(0, 4) == 0)
                        issue(CMD_NEXT, $urandom, $urandom);
                end
                else
                begin
                    op = 2'($urandom_range(0, 3));
                    a  = $urandom;
                    l  = $urandom >> $urandom_range(0, 31);
                    // Keep accidental long transfers out of the run by pushing them out of range.
                    if ((op == CMD_READ || op == CMD_WRITE) && sb.would_start(a, l) &&
                        (l > 32'd262144 || (op == CMD_WRITE && l > 32'(sb.page_bytes) * 16)))
                        a = '1;
                    issue(op, a, l);
                    while (sb.active)
                        issue(CMD_NEXT, $urandom, $urandom);
                end
                if ($urandom_range(0, 49) == 0)
                    drain();
            end
        end

        drain();
        repeat (20) @(posedge clk);
        sb.flush_outstanding();
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
